### rtl/vsf_pkg.sv
package vsf_pkg;

	// Configuration register indexes
	localparam logic [7:0] REG_TEMP_MIN  = 8'd0;
	localparam logic [7:0] REG_TEMP_MAX  = 8'd1;
	localparam logic [7:0] REG_HUMID_MIN = 8'd2;
	localparam logic [7:0] REG_HUMID_MAX = 8'd3;

	// Limit values after reset, tenths
	localparam logic signed [15:0] TEMP_MIN_RST  = -16'sd1000;
	localparam logic signed [15:0] TEMP_MAX_RST  = 16'sd600;
	localparam logic signed [15:0] HUMID_MIN_RST = 16'sd0;
	localparam logic signed [15:0] HUMID_MAX_RST = 16'sd1000;

	// What the back end does with a classified item
	typedef enum logic [1:0] {
		OP_REJECT,
		OP_LIVE,
		OP_STORE
	} op_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_SENT_BUF    = 3'd0,
		KIND_SENT_LIVE   = 3'd1,
		KIND_REJECTED    = 3'd2,
		KIND_STORED      = 3'd3,
		KIND_STORED_DROP = 3'd4
	} kind_t;

	// Classified item passed from front to back
	typedef struct packed {
		logic [15:0] temperature;
		logic [15:0] humidity;
		op_t         op;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [15:0] temperature;
		logic [15:0] humidity;
		kind_t       kind;
		logic        last;
		logic [3:0]  pending;
	} res_t;

endpackage

### rtl/vsf_ram.sv
module vsf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port; read data holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/vsf_fifo.sv
module vsf_fifo #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Payload storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/vsf_front.sv
module vsf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [7:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic signed [15:0]  temperature,
	input  logic signed [15:0]  humidity,
	input  logic                online,
	output vsf_pkg::cmd_t       cmd
);

	logic signed [15:0] temp_min_q;
	logic signed [15:0] temp_max_q;
	logic signed [15:0] humid_min_q;
	logic signed [15:0] humid_max_q;
	logic               in_range;

	// Limit registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q  <= vsf_pkg::TEMP_MIN_RST;
			temp_max_q  <= vsf_pkg::TEMP_MAX_RST;
			humid_min_q <= vsf_pkg::HUMID_MIN_RST;
			humid_max_q <= vsf_pkg::HUMID_MAX_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				vsf_pkg::REG_TEMP_MIN:  temp_min_q  <= cfg_data;
				vsf_pkg::REG_TEMP_MAX:  temp_max_q  <= cfg_data;
				vsf_pkg::REG_HUMID_MIN: humid_min_q <= cfg_data;
				vsf_pkg::REG_HUMID_MAX: humid_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Inclusive range check; crossed limits reject everything
	assign in_range = (temperature >= temp_min_q) && (temperature <= temp_max_q) &&
	                  (humidity >= humid_min_q) && (humidity <= humid_max_q);

	// Classify the item
	always_comb begin
		cmd.temperature = temperature;
		cmd.humidity    = humidity;
		if (!in_range) begin
			cmd.op = vsf_pkg::OP_REJECT;
		end else if (online) begin
			cmd.op = vsf_pkg::OP_LIVE;
		end else begin
			cmd.op = vsf_pkg::OP_STORE;
		end
	end

endmodule

### rtl/vsf_back.sv
module vsf_back #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  vsf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output vsf_pkg::res_t res
);

	localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int PW = (FW > 4) ? FW : 4;

	logic [SW-1:0] rd_slot_q, rd_slot_d;
	logic [SW-1:0] wr_slot_q, wr_slot_d;
	logic [FW-1:0] fill_q, fill_d;
	logic          hold_q, hold_d;
	logic          ram_we;
	logic          ram_re;
	logic [31:0]   ram_rdata;
	logic          emit_buf;
	logic          is_full;
	logic [PW-1:0] pend_ext;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == SW'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	vsf_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_slot_q),
		.wdata ({cmd.humidity, cmd.temperature}),
		.re    (ram_re),
		.raddr (rd_slot_q),
		.rdata (ram_rdata)
	);

	assign is_full = (fill_q == FW'(DEPTH));

	// Carry out the head item; a live item drains one record a cycle while the result queue has room
	always_comb begin
		cmd_pop         = 1'b0;
		res_push        = 1'b0;
		ram_we          = 1'b0;
		ram_re          = 1'b0;
		emit_buf        = 1'b0;
		rd_slot_d       = rd_slot_q;
		wr_slot_d       = wr_slot_q;
		fill_d          = fill_q;
		hold_d          = hold_q;
		res.temperature = cmd.temperature;
		res.humidity    = cmd.humidity;
		res.kind        = vsf_pkg::KIND_REJECTED;
		res.last        = 1'b1;
		if (cmd_valid) begin
			case (cmd.op)
				vsf_pkg::OP_REJECT: begin
					if (!res_full) begin
						res_push = 1'b1;
						cmd_pop  = 1'b1;
					end
				end
				vsf_pkg::OP_STORE: begin
					res.kind = is_full ? vsf_pkg::KIND_STORED_DROP : vsf_pkg::KIND_STORED;
					if (!res_full) begin
						res_push  = 1'b1;
						cmd_pop   = 1'b1;
						ram_we    = 1'b1;
						wr_slot_d = next_slot(wr_slot_q);
						if (is_full) begin
							rd_slot_d = next_slot(rd_slot_q);
						end else begin
							fill_d = fill_q + 1'b1;
						end
					end
				end
				vsf_pkg::OP_LIVE: begin
					if (hold_q) begin
						// Fetched record waits in the RAM read register
						res.temperature = ram_rdata[15:0];
						res.humidity    = ram_rdata[31:16];
						res.kind        = vsf_pkg::KIND_SENT_BUF;
						res.last        = 1'b0;
						if (!res_full) begin
							res_push = 1'b1;
							emit_buf = 1'b1;
							fill_d   = fill_q - 1'b1;
						end
					end else begin
						res.kind = vsf_pkg::KIND_SENT_LIVE;
						if (fill_q == '0 && !res_full) begin
							res_push = 1'b1;
							cmd_pop  = 1'b1;
						end
					end
					// Fetch the next record if one is left and the read register frees
					if ((fill_q > FW'(hold_q)) && (!hold_q || emit_buf)) begin
						ram_re    = 1'b1;
						rd_slot_d = next_slot(rd_slot_q);
					end
					hold_d = ram_re ? 1'b1 : (emit_buf ? 1'b0 : hold_q);
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
		pend_ext    = PW'(fill_d);
		res.pending = pend_ext[3:0];
	end

	// Ring pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_slot_q <= '0;
			wr_slot_q <= '0;
			fill_q    <= '0;
			hold_q    <= 1'b0;
		end else begin
			rd_slot_q <= rd_slot_d;
			wr_slot_q <= wr_slot_d;
			fill_q    <= fill_d;
			hold_q    <= hold_d;
		end
	end

endmodule

### rtl/validated_store_and_forward_fifo.sv
// Channel   Direction  Handshake           Payload
// input     in         push / full         temperature, humidity, online
// result    out        empty / pop         out_temperature, out_humidity, kind, last, pending
// config    in         cfg_write           cfg_index, cfg_data
//
// A rejected or offline reading gives its result once the result queue has room. An online
// reading with an empty ring is sent directly; otherwise the back end first fetches the
// oldest record through the record RAM's registered read, sends every buffered record oldest
// first, then the live record. Reset restores default limits and empties the ring; record RAM
// contents are not cleared. Front and back each stall on their own through a two-item
// queue, and results wait in a two-item output queue.
module validated_store_and_forward_fifo #(
	parameter int DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] temperature,
	input  logic signed [15:0] humidity,
	input  logic               online,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] out_temperature,
	output logic signed [15:0] out_humidity,
	output logic [2:0]         kind,
	output logic               last,
	output logic [3:0]         pending,
	input  logic               cfg_write,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	vsf_pkg::cmd_t                     front_cmd;
	vsf_pkg::cmd_t                     head_cmd;
	logic [$bits(vsf_pkg::cmd_t)-1:0]  head_vec;
	logic                              cmdq_empty;
	logic                              cmd_pop;
	vsf_pkg::res_t                     back_res;
	vsf_pkg::res_t                     out_res;
	logic [$bits(vsf_pkg::res_t)-1:0]  out_vec;
	logic                              res_full;
	logic                              res_push;

	// Front end: limit registers and classification
	vsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.temperature (temperature),
		.humidity    (humidity),
		.online      (online),
		.cmd         (front_cmd)
	);

	// Queue between front and back
	vsf_fifo #(
		.WIDTH($bits(vsf_pkg::cmd_t)),
		.DEPTH(2)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (head_vec),
		.empty  (cmdq_empty)
	);

	assign head_cmd = vsf_pkg::cmd_t'(head_vec);

	// Back end: ring buffer and result generation
	vsf_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmdq_empty),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// Result queue
	vsf_fifo #(
		.WIDTH($bits(vsf_pkg::res_t)),
		.DEPTH(2)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_vec),
		.empty  (empty)
	);

	assign out_res         = vsf_pkg::res_t'(out_vec);
	assign out_temperature = out_res.temperature;
	assign out_humidity    = out_res.humidity;
	assign kind            = out_res.kind;
	assign last            = out_res.last;
	assign pending         = out_res.pending;

endmodule

### tb/testbench.sv
module testbench;

	localparam int PERIOD     = 10;
	localparam int RING_DEPTH = 8;

	// One reading as offered on the input side
	typedef struct {
		logic signed [15:0] temp;
		logic signed [15:0] humid;
		logic               link;
	} reading_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               push        = 1'b0;
	logic signed [15:0] temperature = '0;
	logic signed [15:0] humidity    = '0;
	logic               online      = 1'b0;
	logic               pop         = 1'b0;
	logic               cfg_write   = 1'b0;
	logic [7:0]         cfg_index   = '0;
	logic [15:0]        cfg_data    = '0;
	logic               full;
	logic               empty;
	logic signed [15:0] out_temperature;
	logic signed [15:0] out_humidity;
	logic [2:0]         kind;
	logic               last;
	logic [3:0]         pending;

	validated_store_and_forward_fifo #(
		.DEPTH(RING_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.temperature(temperature),
		.humidity(humidity),
		.online(online),
		.empty(empty),
		.pop(pop),
		.out_temperature(out_temperature),
		.out_humidity(out_humidity),
		.kind(kind),
		.last(last),
		.pending(pending),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Shadow copy of the ring and the limits
	logic [31:0]        ring_mem [RING_DEPTH];
	int                 ring_rd;
	int                 ring_wr;
	int                 ring_fill;
	logic signed [15:0] lim_t_lo = vsf_pkg::TEMP_MIN_RST;
	logic signed [15:0] lim_t_hi = vsf_pkg::TEMP_MAX_RST;
	logic signed [15:0] lim_h_lo = vsf_pkg::HUMID_MIN_RST;
	logic signed [15:0] lim_h_hi = vsf_pkg::HUMID_MAX_RST;

	reading_t      reading_q [$];
	vsf_pkg::res_t due_results [$];
	reading_t      next_reading;

	int  queued_cnt;
	int  accepted_cnt;
	int  checked_cnt;
	int  errors;
	int  drops;
	int  max_drain;
	int  settings_cnt;
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  taken;

	function automatic void note_result(logic [15:0] t, logic [15:0] h, vsf_pkg::kind_t k,
			logic l);
		vsf_pkg::res_t r;
		r.temperature = t;
		r.humidity    = h;
		r.kind        = k;
		r.last        = l;
		r.pending     = ring_fill[3:0];
		due_results.push_back(r);
	endfunction

	// Works out every result that one accepted reading causes
	function automatic void route_reading(reading_t r);
		int             n;
		logic [31:0]    w;
		vsf_pkg::kind_t k;
		n = 0;
		if (r.temp < lim_t_lo || r.temp > lim_t_hi || r.humid < lim_h_lo ||
				r.humid > lim_h_hi) begin
			note_result(r.temp, r.humid, vsf_pkg::KIND_REJECTED, 1'b1);
			return;
		end
		if (r.link) begin
			// drain the ring oldest first, then the live reading
			while (ring_fill > 0) begin
				w = ring_mem[ring_rd];
				ring_rd = (ring_rd + 1) % RING_DEPTH;
				ring_fill--;
				n++;
				note_result(w[15:0], w[31:16], vsf_pkg::KIND_SENT_BUF, 1'b0);
			end
			if (n > max_drain)
				max_drain = n;
			note_result(r.temp, r.humid, vsf_pkg::KIND_SENT_LIVE, 1'b1);
		end else begin
			k = vsf_pkg::KIND_STORED;
			if (ring_fill >= RING_DEPTH) begin
				ring_rd = (ring_rd + 1) % RING_DEPTH;
				ring_fill--;
				k = vsf_pkg::KIND_STORED_DROP;
				drops++;
			end
			ring_mem[ring_wr] = {r.humid, r.temp};
			ring_wr = (ring_wr + 1) % RING_DEPTH;
			ring_fill++;
			note_result(r.temp, r.humid, k, 1'b1);
		end
	endfunction

	// Sampling: accepted items feed the shadow model, results are checked
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			reading_t r;
			r.temp  = temperature;
			r.humid = humidity;
			r.link  = online;
			route_reading(r);
			accepted_cnt++;
			taken = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			vsf_pkg::res_t e;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result: temp %0d humid %0d kind %0d last %0d %s %0d",
						out_temperature, out_humidity, kind, last, "pending", pending);
			end else begin
				e = due_results.pop_front();
				checked_cnt++;
				if (e.temperature !== out_temperature || e.humidity !== out_humidity ||
						e.kind !== kind || e.last !== last || e.pending !== pending) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch on result %0d: expected %0d/%0d kind %0d last %0d %s",
							checked_cnt, $signed(e.temperature), $signed(e.humidity), e.kind,
							e.last, $sformatf("pending %0d", e.pending));
						$display("  got %0d/%0d kind %0d last %0d pending %0d",
							out_temperature, out_humidity, kind, last, pending);
					end
				end
			end
		end
	end

	// Driver: presents the next pending item once the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || taken) begin
			taken = 1'b0;
			if (reading_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_reading = reading_q.pop_front();
				temperature <= next_reading.temp;
				humidity    <= next_reading.humid;
				online      <= next_reading.link;
				push        <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver with random stalls
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic signed [15:0] pick(int lo, int hi);
		int sel;
		if (hi <= lo)
			return 16'(lo);
		sel = $urandom_range(7);
		if (sel == 0)
			return 16'(lo);
		if (sel == 1)
			return 16'(hi);
		return 16'(lo + int'($urandom_range(hi - lo)));
	endfunction

	// A value just or far outside [lo, hi], or anything when the range is full
	function automatic logic signed [15:0] pick_outside(int lo, int hi);
		if (lo > -32768 && (hi >= 32767 || $urandom_range(1) == 0))
			return pick(-32768, lo - 1);
		if (hi < 32767)
			return pick(hi + 1, 32767);
		return 16'($urandom);
	endfunction

	task automatic push_reading(logic signed [15:0] t, logic signed [15:0] h, logic l);
		reading_t r;
		r.temp  = t;
		r.humid = h;
		r.link  = l;
		reading_q.push_back(r);
		queued_cnt++;
	endtask

	// Mostly offline bursts closed by an online reading, with noise and rejects
	task automatic add_traffic(int n);
		int added;
		int sel;
		int burst;
		added = 0;
		while (added < n) begin
			sel = $urandom_range(99);
			if (sel < 12) begin
				push_reading(16'($urandom), 16'($urandom), 1'($urandom));
				added++;
			end else if (sel < 22) begin
				if ($urandom_range(1))
					push_reading(pick_outside(lim_t_lo, lim_t_hi), pick(lim_h_lo, lim_h_hi),
						1'($urandom));
				else
					push_reading(pick(lim_t_lo, lim_t_hi), pick_outside(lim_h_lo, lim_h_hi),
						1'($urandom));
				added++;
			end else begin
				burst = $urandom_range(11);
				for (int j = 0; j < burst && added < n; j++) begin
					push_reading(pick(lim_t_lo, lim_t_hi), pick(lim_h_lo, lim_h_hi), 1'b0);
					added++;
				end
				push_reading(pick(lim_t_lo, lim_t_hi), pick(lim_h_lo, lim_h_hi), 1'b1);
				added++;
			end
		end
	endtask

	// Waits until every item is in and every result is out
	task automatic wait_idle(int extra);
		do
			@(negedge clk);
		while (accepted_cnt != queued_cnt || due_results.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] d);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			vsf_pkg::REG_TEMP_MIN:  lim_t_lo = d;
			vsf_pkg::REG_TEMP_MAX:  lim_t_hi = d;
			vsf_pkg::REG_HUMID_MIN: lim_h_lo = d;
			vsf_pkg::REG_HUMID_MAX: lim_h_hi = d;
			default: ;
		endcase
	endtask

	task automatic set_limits(logic [15:0] tl, logic [15:0] th, logic [15:0] hl,
			logic [15:0] hh);
		write_reg(vsf_pkg::REG_TEMP_MIN, tl);
		write_reg(vsf_pkg::REG_TEMP_MAX, th);
		write_reg(vsf_pkg::REG_HUMID_MIN, hl);
		write_reg(vsf_pkg::REG_HUMID_MAX, hh);
		@(negedge clk);
		cfg_write <= 1'b0;
		settings_cnt++;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(posedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic random_limits();
		logic [15:0] a, b, c, d, s;
		a = 16'($urandom);
		b = 16'($urandom);
		c = 16'($urandom);
		d = 16'($urandom);
		if ($signed(a) > $signed(b)) begin
			s = a;
			a = b;
			b = s;
		end
		if ($signed(c) > $signed(d)) begin
			s = c;
			c = d;
			d = s;
		end
		set_limits(a, b, c, d);
	endtask

	initial begin
		ring_rd   = 0;
		ring_wr   = 0;
		ring_fill = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		settings_cnt = 1;

		// Directed: default limits, no idling
		set_idling(0, 0);
		push_reading(-16'sd1000, 16'sd0, 1'b0);     // lower bounds pass
		push_reading(16'sd600, 16'sd1000, 1'b0);    // upper bounds pass
		push_reading(-16'sd1001, 16'sd500, 1'b1);   // just below temp limit
		push_reading(16'sd601, 16'sd500, 1'b0);     // just above temp limit
		push_reading(16'sd0, -16'sd1, 1'b1);        // just below humidity limit
		push_reading(16'sd0, 16'sd1001, 1'b0);      // just above humidity limit
		push_reading(-16'sd32768, -16'sd32768, 1'b0);
		push_reading(16'sd32767, 16'sd32767, 1'b1); // rejected while online, ring kept
		push_reading(16'sd100, 16'sd500, 1'b1);     // drains two records
		push_reading(16'sd200, 16'sd300, 1'b1);     // online with empty ring
		for (int i = 0; i < RING_DEPTH + 1; i++)
			push_reading(16'(i * 10 - 40), 16'(i * 20), 1'b0); // last one drops oldest
		push_reading(16'sd5, 16'sd5, 1'b1);         // full drain
		wait_idle(2);
		add_traffic(80);
		wait_idle(4);

		// Full range limits, sender idling; pause halfway until all results are in
		set_limits(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		set_idling(50, 0);
		add_traffic(60);
		wait_idle(4);
		add_traffic(60);
		wait_idle(4);

		// Unknown indexes are ignored; equal temp limits, bottom humidity band
		write_reg(8'd4, 16'h0000);
		write_reg(8'hff, 16'h8000);
		set_limits(16'sd250, 16'sd250, 16'h8000, -16'sd30000);
		set_idling(0, 50);
		add_traffic(60);
		wait_idle(4);

		// Crossed temperature limits reject everything
		set_limits(16'sd100, -16'sd100, vsf_pkg::HUMID_MIN_RST, vsf_pkg::HUMID_MAX_RST);
		add_traffic(25);
		wait_idle(4);

		// Random limits, both sides idling
		set_idling(38, 38);
		random_limits();
		add_traffic(50);
		wait_idle(4);
		random_limits();
		add_traffic(50);
		wait_idle(20);

		$display("Checked %0d results from %0d readings: %0d overwrites of the oldest,",
			checked_cnt, accepted_cnt, drops);
		$display("longest drain %0d; limit settings used: %0d, incl. full, equal, crossed, random.",
			max_drain, settings_cnt);
		if (errors == 0 && due_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(PERIOD * 400000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
rtl/vsf_pkg.sv
rtl/vsf_ram.sv
rtl/vsf_fifo.sv
rtl/vsf_front.sv
rtl/vsf_back.sv
rtl/validated_store_and_forward_fifo.sv
tb/testbench.sv
